FILE: rtl/core/cgeet_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the microcode ROM of the CG energy-error estimator.
// No dependencies.
package cgeet_pkg;

  localparam int DATA_W = 32;
  localparam int PROD_W = 56;
  localparam int CNT_W  = 16;
  localparam int LA_W   = 5;
  localparam int ADDR_W = 5;
  localparam int UPC_W  = 5;

  localparam logic [2:0] REG_REL_ACC = 3'd0;
  localparam logic [2:0] REG_EPS     = 3'd1;
  localparam logic [2:0] REG_ABS_ACC = 3'd2;
  localparam logic [2:0] REG_MIN_ACC = 3'd3;
  localparam logic [2:0] REG_MAX_STP = 3'd4;
  localparam logic [2:0] REG_LOOK    = 3'd5;

  typedef struct packed {
    logic [DATA_W-1:0] rel_acc;
    logic [DATA_W-1:0] eps;
    logic [DATA_W-1:0] abs_acc;
    logic [DATA_W-1:0] min_acc;
    logic [CNT_W-1:0]  max_steps;
    logic [LA_W-1:0]   look_ahead;
  } cfg_t;

  typedef struct packed {
    logic func;
    logic sum_more;
    logic out_busy;
  } stat_t;

  typedef enum logic [3:0] {
    MUL_NONE, MUL_ALPHA_RP, MUL_TOL, MUL_MIN, MUL_ABS, MUL_EPS,
    MUL_SL_EL, MUL_SL_EH, MUL_SH_EL, MUL_SH_EH
  } mul_sel_t;

  typedef enum logic [1:0] {ACC_NOP, ACC_LOAD, ACC_ADD32, ACC_ADD64} acc_op_t;

  typedef enum logic [3:0] {
    DP_NOP, DP_CLEAR, DP_UPDATE, DP_SUM, DP_SQ_LOAD, DP_TOL_LOAD,
    DP_TERM, DP_MIND, DP_VTOL, DP_VAN, DP_OUT
  } dp_op_t;

  typedef enum logic [2:0] {J_NEXT, J_ALWAYS, J_FUNC, J_SUM, J_OUT_BUSY} jmp_t;

  typedef struct packed {
    mul_sel_t         mul;
    acc_op_t          acc;
    dp_op_t           dp;
    jmp_t             jmp;
    logic [UPC_W-1:0] tgt;
    logic             last;
  } ucode_t;

  localparam logic [UPC_W-1:0] UA_START = 5'd0;
  localparam logic [UPC_W-1:0] UA_CLR   = 5'd2;
  localparam logic [UPC_W-1:0] UA_SUM   = 5'd3;
  localparam logic [UPC_W-1:0] UA_FLAGS = 5'd4;
  localparam logic [UPC_W-1:0] UA_OUT   = 5'd28;

  localparam ucode_t UC_NOP = '{MUL_NONE, ACC_NOP, DP_NOP, J_NEXT, UA_START, 1'b0};

  function automatic ucode_t uw(input mul_sel_t m, input acc_op_t a, input dp_op_t d,
                                input jmp_t j, input logic [UPC_W-1:0] t, input logic l);
    ucode_t w;
    w.mul  = m;
    w.acc  = a;
    w.dp   = d;
    w.jmp  = j;
    w.tgt  = t;
    w.last = l;
    return w;
  endfunction

  // update: 0,1,3..28   clear: 0,2,4..28
  function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] a);
    ucode_t w;
    case (a)
      5'd0:  w = uw(MUL_ALPHA_RP, ACC_NOP, DP_NOP, J_FUNC, UA_CLR, 1'b0);
      5'd1:  w = uw(MUL_NONE, ACC_NOP, DP_UPDATE, J_ALWAYS, UA_SUM, 1'b0);
      5'd2:  w = uw(MUL_NONE, ACC_NOP, DP_CLEAR, J_ALWAYS, UA_FLAGS, 1'b0);
      5'd3:  w = uw(MUL_NONE, ACC_NOP, DP_SUM, J_SUM, UA_SUM, 1'b0);
      // terminate test
      5'd4:  w = uw(MUL_TOL, ACC_NOP, DP_NOP, J_NEXT, UA_START, 1'b0);
      5'd5:  w = uw(MUL_NONE, ACC_NOP, DP_SQ_LOAD, J_NEXT, UA_START, 1'b0);
      5'd6:  w = uw(MUL_SL_EL, ACC_NOP, DP_NOP, J_NEXT, UA_START, 1'b0);
      5'd7:  w = uw(MUL_SL_EH, ACC_LOAD, DP_NOP, J_NEXT, UA_START, 1'b0);
      5'd8:  w = uw(MUL_SH_EL, ACC_ADD32, DP_NOP, J_NEXT, UA_START, 1'b0);
      5'd9:  w = uw(MUL_SH_EH, ACC_ADD32, DP_NOP, J_NEXT, UA_START, 1'b0);
      5'd10: w = uw(MUL_NONE, ACC_ADD64, DP_NOP, J_NEXT, UA_START, 1'b0);
      // minimal decrease test
      5'd11: w = uw(MUL_MIN, ACC_NOP, DP_TERM, J_NEXT, UA_START, 1'b0);
      5'd12: w = uw(MUL_NONE, ACC_NOP, DP_SQ_LOAD, J_NEXT, UA_START, 1'b0);
      5'd13: w = uw(MUL_SL_EL, ACC_NOP, DP_NOP, J_NEXT, UA_START, 1'b0);
      5'd14: w = uw(MUL_SL_EH, ACC_LOAD, DP_NOP, J_NEXT, UA_START, 1'b0);
      5'd15: w = uw(MUL_SH_EL, ACC_ADD32, DP_NOP, J_NEXT, UA_START, 1'b0);
      5'd16: w = uw(MUL_SH_EH, ACC_ADD32, DP_NOP, J_NEXT, UA_START, 1'b0);
      5'd17: w = uw(MUL_NONE, ACC_ADD64, DP_NOP, J_NEXT, UA_START, 1'b0);
      // vanishing step test
      5'd18: w = uw(MUL_ABS, ACC_NOP, DP_MIND, J_NEXT, UA_START, 1'b0);
      5'd19: w = uw(MUL_EPS, ACC_NOP, DP_TOL_LOAD, J_NEXT, UA_START, 1'b0);
      5'd20: w = uw(MUL_NONE, ACC_NOP, DP_SQ_LOAD, J_NEXT, UA_START, 1'b0);
      5'd21: w = uw(MUL_SL_EL, ACC_NOP, DP_NOP, J_NEXT, UA_START, 1'b0);
      5'd22: w = uw(MUL_SL_EH, ACC_LOAD, DP_NOP, J_NEXT, UA_START, 1'b0);
      5'd23: w = uw(MUL_SH_EL, ACC_ADD32, DP_NOP, J_NEXT, UA_START, 1'b0);
      5'd24: w = uw(MUL_SH_EH, ACC_ADD32, DP_NOP, J_NEXT, UA_START, 1'b0);
      5'd25: w = uw(MUL_NONE, ACC_ADD64, DP_NOP, J_NEXT, UA_START, 1'b0);
      5'd26: w = uw(MUL_NONE, ACC_NOP, DP_VTOL, J_NEXT, UA_START, 1'b0);
      5'd27: w = uw(MUL_NONE, ACC_NOP, DP_VAN, J_NEXT, UA_START, 1'b0);
      5'd28: w = uw(MUL_NONE, ACC_NOP, DP_OUT, J_OUT_BUSY, UA_OUT, 1'b1);
      default: w = UC_NOP;
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/core/cgeet_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cgeet_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                           clk,
  input  logic                                           we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr,
  input  logic [WIDTH-1:0]                               wdata,
  input  logic                                           re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr,
  output logic [WIDTH-1:0]                               rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/cgeet_seq.sv
`timescale 1ns / 1ps
// Microcode sequencer: step counter, ROM lookup and conditional jumps.
// Depends on cgeet_pkg.
module cgeet_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  cgeet_pkg::stat_t  stat,
  output cgeet_pkg::ucode_t ctrl,
  output logic              busy
);
  import cgeet_pkg::*;

  logic [UPC_W-1:0] upc_r, upc_nxt;
  logic             busy_r, busy_nxt;
  ucode_t           word;
  logic             taken;

  always_comb begin
    word = ucode_rom(upc_r);
    case (word.jmp)
      J_NEXT:     taken = 1'b0;
      J_ALWAYS:   taken = 1'b1;
      J_FUNC:     taken = stat.func;
      J_SUM:      taken = stat.sum_more;
      J_OUT_BUSY: taken = stat.out_busy;
      default:    taken = 1'b0;
    endcase
    upc_nxt  = upc_r;
    busy_nxt = busy_r;
    if (!busy_r) begin
      if (start) begin
        busy_nxt = 1'b1;
        upc_nxt  = UA_START;
      end
    end else if (taken) begin
      upc_nxt = word.tgt;
    end else if (word.last) begin
      busy_nxt = 1'b0;
    end else begin
      upc_nxt = upc_r + 1'b1;
    end
    ctrl = busy_r ? word : UC_NOP;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r  <= UA_START;
      busy_r <= 1'b0;
    end else begin
      upc_r  <= upc_nxt;
      busy_r <= busy_nxt;
    end
  end

  assign busy = busy_r;

endmodule

FILE: rtl/core/cgeet_dp.sv
`timescale 1ns / 1ps
// Datapath: shared 32x32 multiplier, 128-bit accumulator, estimator state,
// product ring memory and output register. Depends on cgeet_pkg, cgeet_ram.
module cgeet_dp #(
  parameter int MAX_LOOK_AHEAD = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cgeet_pkg::ucode_t ctrl,
  input  cgeet_pkg::cfg_t   cfg,
  input  logic              in_take,
  input  logic              in_func,
  input  logic [31:0]       in_alpha,
  input  logic signed [31:0] in_qaq,
  input  logic [31:0]       in_rpinvr,
  output cgeet_pkg::stat_t  stat,
  input  logic              out_ready,
  output logic              out_valid,
  output logic              out_terminate,
  output logic              out_vanishing_step,
  output logic              out_minimal_decrease,
  output logic [15:0]       out_step_count
);
  import cgeet_pkg::*;

  localparam int PTR_W = (MAX_LOOK_AHEAD > 1) ? $clog2(MAX_LOOK_AHEAD) : 1;
  localparam int WIN_W = PROD_W + $clog2(MAX_LOOK_AHEAD);
  localparam int LCAP  = (MAX_LOOK_AHEAD < 31) ? MAX_LOOK_AHEAD : 31;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(MAX_LOOK_AHEAD - 1);

  logic              func_r;
  logic [31:0]       alpha_r, qaq_r, rpinvr_r;
  logic [63:0]       mul_r, mul_nxt;
  logic [127:0]      acc_r, acc_nxt;
  logic [63:0]       sq_r, sq_nxt;
  logic [127:0]      tol_r, tol_nxt;
  logic [PTR_W-1:0]  ptr_r, ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [LA_W-1:0]   idx_r, idx_nxt;
  logic              rd_pend_r, rd_pend_nxt;
  logic [WIN_W-1:0]  win_r, win_nxt;
  logic [63:0]       energy_r, energy_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [31:0]       lsl_r, lsl_nxt;
  logic              term_r, term_nxt, van_r, van_nxt, mind_r, mind_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_term_r, out_van_r, out_mind_r;
  logic [CNT_W-1:0]  out_cnt_r;

  logic [31:0]       tol_acc, mul_a, mul_b;
  logic [PROD_W-1:0] prod_sat, ram_rdata;
  logic [64:0]       energy_sum;
  logic [63:0]       energy_sat;
  logic [LA_W-1:0]   win_len, n_len;
  logic              rel_small, ram_we, ram_re, out_busy, out_load;

  cgeet_ram #(.WIDTH(PROD_W), .DEPTH(MAX_LOOK_AHEAD)) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ptr_r),
    .wdata (prod_sat),
    .re    (ram_re),
    .raddr (rd_ptr_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    tol_acc = (cfg.rel_acc > cfg.eps) ? cfg.rel_acc : cfg.eps;
    case (ctrl.mul)
      MUL_ALPHA_RP: begin mul_a = alpha_r;       mul_b = rpinvr_r;        end
      MUL_TOL:      begin mul_a = tol_acc;       mul_b = tol_acc;         end
      MUL_MIN:      begin mul_a = cfg.min_acc;   mul_b = cfg.min_acc;     end
      MUL_ABS:      begin mul_a = cfg.abs_acc;   mul_b = cfg.abs_acc;     end
      MUL_EPS:      begin mul_a = cfg.eps;       mul_b = cfg.eps;         end
      MUL_SL_EL:    begin mul_a = sq_r[31:0];    mul_b = energy_r[31:0];  end
      MUL_SL_EH:    begin mul_a = sq_r[31:0];    mul_b = energy_r[63:32]; end
      MUL_SH_EL:    begin mul_a = sq_r[63:32];   mul_b = energy_r[31:0];  end
      MUL_SH_EH:    begin mul_a = sq_r[63:32];   mul_b = energy_r[63:32]; end
      default:      begin mul_a = '0;            mul_b = '0;              end
    endcase
    mul_nxt = 64'(mul_a) * 64'(mul_b);

    case (ctrl.acc)
      ACC_LOAD:  acc_nxt = {64'd0, mul_r};
      ACC_ADD32: acc_nxt = acc_r + {32'd0, mul_r, 32'd0};
      ACC_ADD64: acc_nxt = acc_r + {mul_r, 64'd0};
      default:   acc_nxt = acc_r;
    endcase
  end

  always_comb begin
    prod_sat   = (|mul_r[63:PROD_W]) ? {PROD_W{1'b1}} : mul_r[PROD_W-1:0];
    energy_sum = {1'b0, energy_r} + 65'(prod_sat);
    energy_sat = energy_sum[64] ? {64{1'b1}} : energy_sum[63:0];
    win_len    = (32'(cfg.look_ahead) > 32'(LCAP)) ? LA_W'(LCAP) : cfg.look_ahead;
    n_len      = (cnt_r < CNT_W'(win_len)) ? cnt_r[LA_W-1:0] : win_len;
    rel_small  = (cnt_r >= CNT_W'(win_len)) && (energy_r != '0) &&
                 ({64'(win_r), 64'd0} < acc_r);
    out_busy   = out_valid_r && !out_ready;
    out_load   = (ctrl.dp == DP_OUT) && !out_busy;

    ptr_nxt     = ptr_r;
    rd_ptr_nxt  = rd_ptr_r;
    idx_nxt     = idx_r;
    rd_pend_nxt = 1'b0;
    win_nxt     = rd_pend_r ? win_r + WIN_W'(ram_rdata) : win_r;
    energy_nxt  = energy_r;
    cnt_nxt     = cnt_r;
    lsl_nxt     = lsl_r;
    sq_nxt      = sq_r;
    tol_nxt     = tol_r;
    term_nxt    = term_r;
    van_nxt     = van_r;
    mind_nxt    = mind_r;
    ram_we      = 1'b0;
    ram_re      = 1'b0;

    case (ctrl.dp)
      DP_CLEAR: begin
        ptr_nxt    = '0;
        win_nxt    = '0;
        energy_nxt = '0;
        cnt_nxt    = '0;
      end
      DP_UPDATE: begin
        ram_we     = 1'b1;
        ptr_nxt    = (ptr_r == PTR_LAST) ? '0 : ptr_r + 1'b1;
        rd_ptr_nxt = ptr_r;
        idx_nxt    = '0;
        win_nxt    = '0;
        energy_nxt = energy_sat;
        cnt_nxt    = (cnt_r == {CNT_W{1'b1}}) ? cnt_r : cnt_r + 1'b1;
        lsl_nxt    = qaq_r[31] ? (~qaq_r + 32'd1) : qaq_r;
      end
      DP_SUM: begin
        if (idx_r < n_len) begin
          ram_re      = 1'b1;
          rd_pend_nxt = 1'b1;
          idx_nxt     = idx_r + 1'b1;
          rd_ptr_nxt  = (rd_ptr_r == '0) ? PTR_LAST : rd_ptr_r - 1'b1;
        end
      end
      DP_SQ_LOAD:  sq_nxt = mul_r;
      DP_TOL_LOAD: tol_nxt = {32'd0, mul_r, 32'd0};
      DP_TERM: begin
        term_nxt = (cnt_r > cfg.max_steps) ||
                   ((cnt_r > CNT_W'(win_len)) && rel_small);
      end
      DP_MIND: mind_nxt = rel_small;
      DP_VTOL: begin
        if ((tol_r < {energy_r, 64'd0}) && (acc_r < tol_r)) begin
          tol_nxt = acc_r;
        end
      end
      DP_VAN:  van_nxt = {16'd0, lsl_r, 80'd0} < tol_r;
      default: ;
    endcase

    out_valid_nxt = out_valid_r && !out_ready;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end

    stat.func     = func_r;
    stat.sum_more = idx_r < n_len;
    stat.out_busy = out_busy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r       <= '0;
      win_r       <= '0;
      energy_r    <= '0;
      cnt_r       <= '0;
      lsl_r       <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      ptr_r       <= ptr_nxt;
      win_r       <= win_nxt;
      energy_r    <= energy_nxt;
      cnt_r       <= cnt_nxt;
      lsl_r       <= lsl_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      func_r   <= in_func;
      alpha_r  <= in_alpha;
      qaq_r    <= in_qaq;
      rpinvr_r <= in_rpinvr;
    end
    mul_r    <= mul_nxt;
    acc_r    <= acc_nxt;
    sq_r     <= sq_nxt;
    tol_r    <= tol_nxt;
    rd_ptr_r <= rd_ptr_nxt;
    idx_r    <= idx_nxt;
    term_r   <= term_nxt;
    van_r    <= van_nxt;
    mind_r   <= mind_nxt;
    if (out_load) begin
      out_term_r <= term_r;
      out_van_r  <= van_r;
      out_mind_r <= mind_r;
      out_cnt_r  <= cnt_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_terminate        = out_term_r;
  assign out_vanishing_step   = out_van_r;
  assign out_minimal_decrease = out_mind_r;
  assign out_step_count       = out_cnt_r;

endmodule

FILE: rtl/core/cg_energy_error_termination_core.sv
`timescale 1ns / 1ps
// CG energy-error termination core: top level with APB register file, sequencer and
// datapath. Depends on cgeet_pkg, cgeet_seq, cgeet_dp.
// Each input transfer is one CG iteration (func 0) or a clear (func 1) and yields one
// result transfer with the terminate, vanishing-step and minimal-decrease flags and the
// step count. The core handles one item at a time: an update steps through the update,
// a sum of the newest n ring entries, n = min(look_ahead, MAX_LOOK_AHEAD, step count
// after the update), and the three tests, and a clear through the clear and the tests;
// the last step is held longer while the previous result still waits in the output
// register. The time taken is set by the single shared 32x32 multiplier, which forms
// every squared tolerance and each 64x64 tolerance-times-energy product as four
// partial products, and by the product ring, whose newest n entries are summed one
// memory read per cycle. Results wait in an output register; in_ready rises as soon
// as the sequencer finishes, whether or not the last result has been taken. Registers
// (32-bit, byte address 4*i): relative_accuracy, machine_epsilon, absolute_accuracy,
// minimal_accuracy, max_steps, look_ahead; write them only while the core is idle.
module cg_energy_error_termination_core #(
  parameter int MAX_LOOK_AHEAD = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [cgeet_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_func,
  input  logic [31:0]       in_alpha,
  input  logic signed [31:0] in_qaq,
  input  logic [31:0]       in_rpinvr,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_terminate,
  output logic              out_vanishing_step,
  output logic              out_minimal_decrease,
  output logic [15:0]       out_step_count
);
  import cgeet_pkg::*;

  logic [DATA_W-1:0] rel_r, eps_r, abs_r, min_r;
  logic [CNT_W-1:0]  max_steps_r;
  logic [LA_W-1:0]   look_r;
  logic              wr_en, in_take, busy;
  logic [2:0]        reg_idx;
  cfg_t              cfg;
  stat_t             stat;
  ucode_t            ctrl;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];
  assign in_take = in_valid && in_ready;
  assign in_ready = !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rel_r       <= '0;
      eps_r       <= 32'd1;
      abs_r       <= '0;
      min_r       <= '0;
      max_steps_r <= 16'd1000;
      look_r      <= 5'd5;
    end else if (wr_en) begin
      case (reg_idx)
        REG_REL_ACC: rel_r       <= pwdata;
        REG_EPS:     eps_r       <= pwdata;
        REG_ABS_ACC: abs_r       <= pwdata;
        REG_MIN_ACC: min_r       <= pwdata;
        REG_MAX_STP: max_steps_r <= pwdata[CNT_W-1:0];
        REG_LOOK:    look_r      <= pwdata[LA_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_REL_ACC: prdata = rel_r;
      REG_EPS:     prdata = eps_r;
      REG_ABS_ACC: prdata = abs_r;
      REG_MIN_ACC: prdata = min_r;
      REG_MAX_STP: prdata = 32'(max_steps_r);
      REG_LOOK:    prdata = 32'(look_r);
      default:     prdata = '0;
    endcase
    cfg.rel_acc    = rel_r;
    cfg.eps        = eps_r;
    cfg.abs_acc    = abs_r;
    cfg.min_acc    = min_r;
    cfg.max_steps  = max_steps_r;
    cfg.look_ahead = look_r;
  end

  cgeet_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_take),
    .stat  (stat),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  cgeet_dp #(.MAX_LOOK_AHEAD(MAX_LOOK_AHEAD)) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .ctrl                 (ctrl),
    .cfg                  (cfg),
    .in_take              (in_take),
    .in_func              (in_func),
    .in_alpha             (in_alpha),
    .in_qaq               (in_qaq),
    .in_rpinvr            (in_rpinvr),
    .stat                 (stat),
    .out_ready            (out_ready),
    .out_valid            (out_valid),
    .out_terminate        (out_terminate),
    .out_vanishing_step   (out_vanishing_step),
    .out_minimal_decrease (out_minimal_decrease),
    .out_step_count       (out_step_count)
  );

endmodule

FILE: rtl/core/cgeet_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the CG energy-error termination core, bound to the top level.
// Depends on cg_energy_error_termination_core.
module cgeet_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_terminate,
  input logic        out_minimal_decrease,
  input logic [15:0] out_step_count
);

  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("core took a second transfer while busy");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without work in flight");

  a_empty_no_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_step_count == 16'd0) |-> !out_terminate && !out_minimal_decrease)
    else $error("flags set with no stored products");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_step_count) &&
                                $stable(out_terminate))
    else $error("stalled result changed");

endmodule

bind cg_energy_error_termination_core cgeet_chk u_chk (.*);

FILE: verif/cg_energy_error_termination_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for cg_energy_error_termination_core: random and directed CG
// iteration streams with a bit-exact flag predictor. Depends on cgeet_pkg and the core.
module cg_energy_error_termination_core_tb;
  import cgeet_pkg::*;

  localparam int          MAX_LA      = 16;
  localparam int          QUIET_LIMIT = 3000;
  localparam logic        FUNC_UPDATE = 1'b0;
  localparam logic        FUNC_CLEAR  = 1'b1;
  localparam logic [63:0] PROD_SAT    = (64'd1 << PROD_W) - 64'd1;

  typedef struct packed {
    logic        func;
    logic [31:0] alpha;
    logic [31:0] qaq;
    logic [31:0] rpinvr;
    logic        drain;
  } cg_item_t;

  typedef struct packed {
    logic        terminate;
    logic        vanishing;
    logic        min_decrease;
    logic [15:0] steps;
  } flags_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                in_func = 1'b0;
  logic [31:0]         in_alpha = '0;
  logic signed [31:0]  in_qaq = '0;
  logic [31:0]         in_rpinvr = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_terminate;
  logic                out_vanishing_step;
  logic                out_minimal_decrease;
  logic [15:0]         out_step_count;

  cg_energy_error_termination_core dut (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .in_func(in_func), .in_alpha(in_alpha),
    .in_qaq(in_qaq), .in_rpinvr(in_rpinvr),
    .out_valid(out_valid), .out_ready(out_ready), .out_terminate(out_terminate),
    .out_vanishing_step(out_vanishing_step), .out_minimal_decrease(out_minimal_decrease),
    .out_step_count(out_step_count)
  );

  always #6 clk = ~clk;

  cg_item_t    item_q[$];
  flags_t      flags_due[$];
  cg_item_t    cur_item;
  flags_t      want;
  int unsigned n_queued = 0;
  int unsigned n_taken = 0;
  int unsigned n_flagged = 0;
  int unsigned errors = 0;
  int unsigned quiet = 0;

  // estimator shadow state and register copy
  cfg_t        regs;
  logic [55:0] ring_m [MAX_LA];
  logic [3:0]  ptr_m;
  logic [63:0] window_m;
  logic [63:0] energy_m;
  logic [31:0] step_len_m;
  logic [15:0] iters_m;

  function automatic int win_len();
    return (regs.look_ahead > MAX_LA) ? MAX_LA : int'(regs.look_ahead);
  endfunction

  function automatic logic rel_below(input logic [63:0] tol_sq);
    logic [127:0] lhs, rhs;
    lhs = {window_m, 64'd0};
    rhs = {64'd0, tol_sq} * {64'd0, energy_m};
    return (int'(iters_m) >= win_len()) && (energy_m != 64'd0) && (lhs < rhs);
  endfunction

  function automatic void clear_estimator();
    for (int i = 0; i < MAX_LA; i++) ring_m[i] = '0;
    ptr_m    = '0;
    window_m = '0;
    energy_m = '0;
    iters_m  = '0;
  endfunction

  function automatic flags_t advance_estimator(input cg_item_t it);
    logic [63:0]  prod, abs_sq, eps_sq;
    logic [64:0]  esum;
    logic [31:0]  tol;
    logic [127:0] thr, scaled;
    flags_t       v;
    if (it.func == FUNC_CLEAR) begin
      clear_estimator();
    end else begin
      prod = {32'd0, it.alpha} * {32'd0, it.rpinvr};
      if (prod > PROD_SAT) prod = PROD_SAT;
      ring_m[ptr_m] = prod[55:0];
      ptr_m = ptr_m + 4'd1;
      esum = {1'b0, energy_m} + {1'b0, prod};
      energy_m = esum[64] ? '1 : esum[63:0];
      if (iters_m != 16'hFFFF) iters_m = iters_m + 16'd1;
      step_len_m = it.qaq[31] ? (32'd0 - it.qaq) : it.qaq;
      window_m = '0;
      for (int i = 0; i < win_len(); i++)
        window_m = window_m + 64'(ring_m[ptr_m - 4'd1 - 4'(i)]);
    end
    tol = (regs.rel_acc > regs.eps) ? regs.rel_acc : regs.eps;
    v.terminate = (iters_m > regs.max_steps) ||
                  ((int'(iters_m) > win_len()) && rel_below({32'd0, tol} * {32'd0, tol}));
    abs_sq = {32'd0, regs.abs_acc} * {32'd0, regs.abs_acc};
    eps_sq = {32'd0, regs.eps} * {32'd0, regs.eps};
    thr = {32'd0, abs_sq, 32'd0};
    if (thr < {energy_m, 64'd0}) begin
      scaled = {64'd0, eps_sq} * {64'd0, energy_m};
      if (scaled < thr) thr = scaled;
    end
    v.vanishing = {16'd0, step_len_m, 16'd0, 64'd0} < thr;
    v.min_decrease = rel_below({32'd0, regs.min_acc} * {32'd0, regs.min_acc});
    v.steps = iters_m;
    return v;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp_val);
    $display("[%0t] mismatch %s: got %0h expected %0h (result %0d)", $realtime, what,
             got, exp_val, n_flagged);
    errors++;
  endtask

  function automatic int unsigned send_idle_pct();
    if (n_taken < 190) return 6;
    if (n_taken < 380) return 53;
    return 0;
  endfunction

  function automatic int unsigned recv_idle_pct();
    if (n_taken < 190) return 53;
    if (n_taken < 380) return 6;
    return 0;
  endfunction

  // driver
  always @(posedge clk) begin
    logic taken_now;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      taken_now = in_valid && in_ready;
      if (taken_now) begin
        flags_due.insert(flags_due.size(), advance_estimator(cur_item));
        n_taken <= n_taken + 1;
      end
      if (!in_valid || in_ready) begin
        if (item_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct() &&
            (!item_q[0].drain || n_flagged == n_taken + 32'(taken_now))) begin
          cur_item = item_q.pop_front();
          in_valid  <= 1'b1;
          in_func   <= cur_item.func;
          in_alpha  <= cur_item.alpha;
          in_qaq    <= cur_item.qaq;
          in_rpinvr <= cur_item.rpinvr;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct());
      if (out_valid && out_ready) begin
        if (flags_due.size() == 0) begin
          report_mismatch("result transfer with nothing expected", 64'(out_step_count),
                          64'd0);
        end else begin
          want = flags_due.pop_front();
          if (out_terminate !== want.terminate)
            report_mismatch("terminate", 64'(out_terminate), 64'(want.terminate));
          if (out_vanishing_step !== want.vanishing)
            report_mismatch("vanishing_step", 64'(out_vanishing_step),
                            64'(want.vanishing));
          if (out_minimal_decrease !== want.min_decrease)
            report_mismatch("minimal_decrease", 64'(out_minimal_decrease),
                            64'(want.min_decrease));
          if (out_step_count !== want.steps)
            report_mismatch("step_count", 64'(out_step_count), 64'(want.steps));
          n_flagged <= n_flagged + 1;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) ||
        (out_valid && out_ready && flags_due.size() != 0) ||
        (psel && penable && pwrite && pready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == QUIET_LIMIT) begin
        $display("FAIL cg_energy_error_termination_core");
        $finish;
      end
    end
  end

  task automatic push_item(input logic func, input logic [31:0] a, input logic [31:0] q,
                           input logic [31:0] r, input logic drain);
    cg_item_t it;
    it.func   = func;
    it.alpha  = a;
    it.qaq    = q;
    it.rpinvr = r;
    it.drain  = drain;
    item_q.insert(item_q.size(), it);
    n_queued++;
  endtask

  function automatic logic [31:0] rand_qaq();
    case ($urandom_range(0, 3))
      0: return 32'($urandom_range(0, 131070)) - 32'd65535;
      1: return 32'($urandom_range(0, 255));
      2: return 32'($urandom) >> $urandom_range(0, 24);
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_noise(input int n);
    for (int k = 0; k < n; k++)
      push_item($urandom_range(0, 4) == 0, $urandom, $urandom, $urandom, 1'b0);
  endtask

  // CG run: a clear, then updates with mostly shrinking r'P^-1r and some noise items, or saturating ones
  task automatic queue_cg_run(input int n, input bit saturate);
    logic [31:0] a, r;
    push_item(FUNC_CLEAR, $urandom, $urandom, $urandom, $urandom_range(0, 3) == 0);
    a = 32'($urandom) >> $urandom_range(0, 16);
    r = 32'($urandom) >> $urandom_range(0, 8);
    for (int k = 0; k < n; k++) begin
      if (saturate) begin
        a = $urandom | 32'hF000_0000;
        r = $urandom | 32'hF000_0000;
      end else begin
        if ($urandom_range(0, 24) == 0) queue_noise(1);
        r = (r >> $urandom_range(0, 2)) ^ 32'($urandom_range(0, 3));
        a = a ^ 32'($urandom_range(0, 255));
      end
      push_item(FUNC_UPDATE, a, rand_qaq(), r, 1'b0);
    end
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_REL_ACC: regs.rel_acc    = v;
      REG_EPS:     regs.eps        = v;
      REG_ABS_ACC: regs.abs_acc    = v;
      REG_MIN_ACC: regs.min_acc    = v;
      REG_MAX_STP: regs.max_steps  = v[15:0];
      REG_LOOK:    regs.look_ahead = v[4:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [31:0] rel, input logic [31:0] eps,
                              input logic [31:0] abs_a, input logic [31:0] min_a,
                              input logic [15:0] steps, input logic [4:0] look);
    cfg_write(REG_REL_ACC, rel);
    cfg_write(REG_EPS, eps);
    cfg_write(REG_ABS_ACC, abs_a);
    cfg_write(REG_MIN_ACC, min_a);
    cfg_write(REG_MAX_STP, {16'd0, steps});
    cfg_write(REG_LOOK, {27'd0, look});
  endtask

  task automatic wait_idle();
    while (n_flagged != n_queued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int unsigned budget;
    regs.rel_acc    = '0;
    regs.eps        = 32'd1;
    regs.abs_acc    = '0;
    regs.min_acc    = '0;
    regs.max_steps  = 16'd1000;
    regs.look_ahead = 5'd5;
    clear_estimator();
    step_len_m = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed
    program_regs(32'h8000_0000, 32'd1, 32'hFFFF_FFFF, 32'h4000_0000, 16'd12, 5'd4);
    push_item(FUNC_CLEAR, '1, '1, '1, 1'b0);
    push_item(FUNC_UPDATE, 32'd0, 32'd0, 32'd0, 1'b0);
    push_item(FUNC_UPDATE, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
    push_item(FUNC_UPDATE, 32'h0001_0000, 32'h7FFF_FFFF, 32'h0001_0000, 1'b0);
    push_item(FUNC_UPDATE, 32'h0001_0000, 32'hFFFF_FFFF, 32'h0000_8000, 1'b0);
    for (int k = 2; k < 15; k++)
      push_item(FUNC_UPDATE, 32'h0001_0000, 32'(k), 32'h0001_0000 >> k, 1'b0);
    push_item(FUNC_CLEAR, 32'd0, 32'd0, 32'd0, 1'b1);
    push_item(FUNC_UPDATE, 32'd1, 32'h0001_0000, 32'd1, 1'b0);

    for (int p = 1; p <= 7; p++) begin
      wait_idle();
      case (p)
        2: program_regs('0, '0, '0, '0, '0, '0);
        3: program_regs('1, '1, '1, '1, 16'hFFFF, 5'd16);
        4: program_regs($urandom, 32'($urandom) >> 16, $urandom, $urandom, 16'hFFFF, 5'd1);
        default: program_regs($urandom, 32'($urandom) >> $urandom_range(0, 31), $urandom,
                              $urandom, 16'($urandom_range(0, 60)),
                              5'($urandom_range(0, 16)));
      endcase
      if (p == 3) queue_cg_run(258, 1'b1);
      budget = n_queued + 30;
      while (n_queued < budget) begin
        if ($urandom_range(0, 4) == 0) queue_noise($urandom_range(1, 6));
        else queue_cg_run($urandom_range(3, 30), 1'b0);
      end
    end

    wait_idle();
    repeat (60) @(posedge clk);
    if (flags_due.size() != 0)
      report_mismatch("expected results left over", 64'(flags_due.size()), 64'd0);
    if (errors == 0) begin
      $display("PASS cg_energy_error_termination_core");
    end else begin
      $display("FAIL cg_energy_error_termination_core");
    end
    $finish;
  end

endmodule

FILE: cg_energy_error_termination_core.f
rtl/core/cgeet_pkg.sv
rtl/core/cgeet_ram.sv
rtl/core/cgeet_seq.sv
rtl/core/cgeet_dp.sv
rtl/core/cg_energy_error_termination_core.sv
rtl/core/cgeet_chk.sv
verif/cg_energy_error_termination_core_tb.sv
